>>> hw/rtl/ordered_table_insert_remove_search_top_macros.svh
// Assertion macros shared by the ordered table RTL.
// Included by the top level; depends on nothing else.
`ifndef ORDERED_TABLE_INSERT_REMOVE_SEARCH_TOP_MACROS_SVH
`define ORDERED_TABLE_INSERT_REMOVE_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ots_pkg.sv
// Package for the ordered table: sizes, operation codes, request and
// response types, and the controller/datapath command and status structs.
package ots_pkg;

    localparam int DEPTH       = 256;
    localparam int ENTRY_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int KIND_W      = 2;
    localparam int POS_W       = 9;
    localparam int VALUE_W     = 32;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic             found;
        logic [POS_W-1:0] found_position;
        logic [POS_W-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic req_load;
        logic init;
        logic ins_step;
        logic ins_finish;
        logic rem_step;
        logic rem_finish;
        logic srch_cmp;
        logic rsp_load;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              legal;
        logic              ins_last;
        logic              rem_last;
        logic              srch_end;
        logic              rsp_full;
    } t_stat;

endpackage

>>> hw/rtl/ots_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ots_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ots_ctrl.sv
// Controller state machine for the ordered table.
// Depends on ots_pkg for the command and status structs and operation codes.
module ots_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  logic          i_rsp_ready,
    input  ots_pkg::t_stat i_stat,
    output ots_pkg::t_cmd  o_cmd
);
    import ots_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_REM  = 3'd3;
    localparam logic [2:0] S_SRD  = 3'd4;
    localparam logic [2:0] S_SCMP = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.init = 1'b1;
                if (!i_stat.legal) begin
                    n_state = S_RESP;
                end else begin
                    unique case (i_stat.kind)
                        KIND_INSERT: n_state = S_INS;
                        KIND_REMOVE: n_state = S_REM;
                        KIND_SEARCH: n_state = S_SRD;
                        default:     n_state = S_RESP;
                    endcase
                end
            end
            S_INS: begin
                if (i_stat.ins_last) begin
                    o_cmd.ins_finish = 1'b1;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.ins_step = 1'b1;
                end
            end
            S_REM: begin
                if (i_stat.rem_last) begin
                    o_cmd.rem_finish = 1'b1;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.rem_step = 1'b1;
                end
            end
            S_SRD: begin
                // The read address follows the current bounds, so the
                // entry at the midpoint arrives in the compare state.
                n_state = i_stat.srch_end ? S_RESP : S_SCMP;
            end
            S_SCMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = S_SRD;
            end
            S_RESP: begin
                if (!i_stat.rsp_full || i_rsp_ready) begin
                    o_cmd.rsp_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

>>> hw/rtl/ots_dp.sv
// Datapath for the ordered table: entry memory, count, shift pointers,
// search bounds, key compare and the response register.
// Depends on ots_pkg and ots_ram.
module ots_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  ots_pkg::t_req  i_req,
    input  ots_pkg::t_cmd  i_cmd,
    input  logic           i_rsp_ready,
    output ots_pkg::t_stat o_stat,
    output ots_pkg::t_rsp  o_rsp,
    output logic           o_rsp_valid
);
    import ots_pkg::*;

    logic                   r_signed;
    t_req                   r_req;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_ptr;
    logic [ADDR_W-1:0]      r_wptr;
    logic                   r_pend;
    logic [CNT_W-1:0]       r_lo;
    logic [CNT_W-1:0]       r_hi;
    logic                   r_ok;
    logic                   r_found;
    t_rsp                   r_rsp;
    logic                   r_rsp_valid;

    logic [CNT_W-1:0]       ptr_dec;
    logic [CNT_W-1:0]       ptr_inc;
    logic [CNT_W:0]         bound_sum;
    logic [CNT_W-1:0]       mid;
    logic [ENTRY_WIDTH-1:0] key;
    logic [ENTRY_WIDTH-1:0] rdata;
    logic [ENTRY_WIDTH-1:0] sign_flip;
    logic                   entry_less;
    logic                   legal;
    logic                   ins_more;
    logic                   rem_more;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ENTRY_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;

    assign ptr_dec   = r_ptr - CNT_W'(1);
    assign ptr_inc   = r_ptr + CNT_W'(1);
    assign bound_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = bound_sum[CNT_W:1];
    assign key       = r_req.value[ENTRY_WIDTH-1:0];

    // Two's complement order is unsigned order with the sign bits flipped.
    assign sign_flip  = {r_signed, {(ENTRY_WIDTH-1){1'b0}}};
    assign entry_less = (rdata ^ sign_flip) < (key ^ sign_flip);

    assign ins_more = (r_ptr != r_req.position);
    assign rem_more = (r_ptr < r_count);

    always_comb begin
        case (r_req.kind)
            KIND_INSERT: legal = (r_count != CNT_W'(DEPTH)) && (r_req.position <= r_count);
            KIND_REMOVE: legal = (r_req.position < r_count);
            KIND_SEARCH: legal = 1'b1;
            default:     legal = 1'b0;
        endcase
    end

    always_comb begin
        case (r_req.kind)
            KIND_INSERT: ram_raddr = ptr_dec[ADDR_W-1:0];
            KIND_REMOVE: ram_raddr = r_ptr[ADDR_W-1:0];
            default:     ram_raddr = mid[ADDR_W-1:0];
        endcase
    end

    assign ram_we    = i_cmd.ins_finish || ((i_cmd.ins_step || i_cmd.rem_step) && r_pend);
    assign ram_waddr = i_cmd.ins_finish ? r_req.position[ADDR_W-1:0] : r_wptr;
    assign ram_wdata = i_cmd.ins_finish ? key : rdata;

    ots_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed    <= 1'b0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_signed <= i_cfg_wdata;
            end
            if (i_cmd.ins_finish) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.rem_finish) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.init) begin
                r_pend <= 1'b0;
            end else if (i_cmd.ins_step) begin
                r_pend <= ins_more;
            end else if (i_cmd.rem_step) begin
                r_pend <= rem_more;
            end
            if (i_cmd.rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req <= i_req;
        end
        if (i_cmd.init) begin
            r_ok    <= legal;
            r_found <= 1'b0;
            r_lo    <= '0;
            r_hi    <= r_count;
            r_ptr   <= (r_req.kind == KIND_REMOVE) ? (r_req.position + CNT_W'(1)) : r_count;
        end
        if (i_cmd.ins_step && ins_more) begin
            r_ptr  <= ptr_dec;
            r_wptr <= r_ptr[ADDR_W-1:0];
        end
        if (i_cmd.rem_step && rem_more) begin
            r_ptr  <= ptr_inc;
            r_wptr <= ptr_dec[ADDR_W-1:0];
        end
        if (i_cmd.srch_cmp) begin
            if (entry_less) begin
                r_lo <= mid + CNT_W'(1);
            end else begin
                // The final lower bound is the last midpoint that was not
                // less than the key, so its equality test is the answer.
                r_hi    <= mid;
                r_found <= (rdata == key);
            end
        end
        if (i_cmd.rsp_load) begin
            r_rsp.ok             <= r_ok;
            r_rsp.found          <= r_found;
            r_rsp.found_position <= (r_req.kind == KIND_SEARCH) ? r_lo : '0;
            r_rsp.entry_count    <= r_count;
        end
    end

    assign o_stat.kind     = r_req.kind;
    assign o_stat.legal    = legal;
    assign o_stat.ins_last = !ins_more && !r_pend;
    assign o_stat.rem_last = !rem_more && !r_pend;
    assign o_stat.srch_end = (r_lo >= r_hi);
    assign o_stat.rsp_full = r_rsp_valid;

    assign o_rsp       = r_rsp;
    assign o_rsp_valid = r_rsp_valid;

endmodule

>>> hw/rtl/ordered_table_insert_remove_search_top.sv
// Top level of the ordered table: controller, datapath and assertions.
// Depends on ots_pkg, ots_ctrl, ots_dp and the assertion macro header.
//
// Usage: the block keeps up to 256 ordered 32-bit entries in one memory.
// A request (i_req_valid / o_req_ready, payload i_req) is an insert at a
// position, a remove at a position, or a lower-bound search for a key.
// Every request yields exactly one response (o_rsp_valid / i_rsp_ready,
// payload o_rsp) with ok, found, found_position and the new entry count.
// Illegal requests (full table, position out of range, unused kind) return
// ok=0 and change nothing.
// From acceptance, the controller passes through a dispatch state, then
// the insert or remove shift steps, in which each moved entry passes once
// through the single memory port, and then the response state. A search
// alternates a read and a compare per halving before the response state.
// The controller returns to idle after each response.
// One request is worked on at a time; o_req_ready is high only when the
// controller is idle. The response sits in an output register, so a new
// request is taken while the last response still waits; if the receiver
// stalls, the next response waits inside the block until that register
// frees. Reset clears the count, the ordering bit (unsigned) and the
// response valid; the memory contents are not cleared and need no pass.
// i_cfg_we writes i_cfg_wdata as the signed-order bit; write it only idle.
`include "ordered_table_insert_remove_search_top_macros.svh"

module ordered_table_insert_remove_search_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ots_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output ots_pkg::t_rsp o_rsp
);
    import ots_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // The controller sequences one request at a time and drives the
    // datapath only through the command struct.
    ots_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The datapath holds the entries, the count and the response register.
    ots_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .i_rsp_ready (i_rsp_ready),
        .o_stat      (stat),
        .o_rsp       (o_rsp),
        .o_rsp_valid (o_rsp_valid)
    );

    // Once a request is taken the controller must be busy on the next cycle.
    `OTS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req_valid && o_req_ready, !o_req_ready, "request accepted but controller still idle")

    // A refused request reports no match and position zero.
    `OTS_ASSERT_NOW(a_refused_clean, i_clk, i_rst_n, o_rsp_valid && !o_rsp.ok, !o_rsp.found && (o_rsp.found_position == '0), "refused response carries search fields")

    // A match always points at an occupied entry.
    `OTS_ASSERT_NOW(a_found_in_range, i_clk, i_rst_n, o_rsp_valid && o_rsp.found, o_rsp.found_position < o_rsp.entry_count, "found position beyond entry count")

endmodule
